// ===== rtl/core/shbs_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 byte-stream hasher.
// Used by the top level, the round unit and both testbench files; depends on nothing else.

package shbs_pkg;

    typedef logic [31:0]      t_word;
    // Working variables a..h, index 0 is a.
    typedef logic [7:0][31:0] t_work;

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic load;
        logic step;
    } t_round_ctl;

    // Input function codes carried in tuser.
    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    localparam int          NUM_WORDS = 8;
    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [5:0]  LEN_POS   = 6'd56;
    localparam logic [5:0]  LAST_POS  = 6'd63;
    localparam logic [5:0]  LAST_RND  = 6'd63;
    localparam logic [2:0]  LAST_IDX  = 3'd7;

    localparam t_word H_INIT [NUM_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Compression functions on a and e.
    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Message schedule functions.
    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    // Next schedule word from the taps t-16, t-15, t-7 and t-2.
    function automatic t_word sched_next(input t_word w16, input t_word w15,
                                         input t_word w7, input t_word w2);
        return w16 + small_sigma0(w15) + w7 + small_sigma1(w2);
    endfunction

endpackage

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
// SHA-256 over a byte stream: one message byte per input transfer, digest on finish.
// An absorb transfer shifts its byte into the block buffer; the 64th byte of a block starts
// the rounds (one round per cycle) and a fold, and the input is not ready meanwhile.
// A finish transfer pads one byte per cycle up to the block end, compresses one or two
// blocks, then sends eight digest words, one per output transfer.
// Reset (synchronous, active low) restores the initial hash and a zero length.
// Depends on shbs_pkg and shbs_round.

module sha256_byte_stream_hasher
    import shbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    t_state       r_state, n_state;
    logic [5:0]   r_fill, n_fill;
    logic [63:0]  r_msg, n_msg;
    t_work        r_h, n_h;
    logic [511:0] r_win, n_win;
    logic [5:0]   r_cnt, n_cnt;
    logic [2:0]   r_oidx, n_oidx;
    logic         r_pad, n_pad;
    logic         r_final, n_final;

    logic         in_acc;
    logic         out_acc;
    t_round_ctl   round_ctl;
    t_work        work;
    t_word        w_new;
    logic [63:0]  bit_len;
    logic [7:0]   len_byte;
    logic [7:0]   pad_fill;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign out_acc       = m_axis_tvalid & m_axis_tready;

    // Schedule word from the window taps: oldest word sits in the top 32 bits.
    assign w_new = sched_next(r_win[511:480], r_win[479:448], r_win[223:192], r_win[63:32]);

    // Big-endian length byte for buffer positions 56 to 63.
    assign bit_len  = {r_msg[60:0], 3'b000};
    assign len_byte = 8'(bit_len >> {~r_fill[2:0], 3'b000});
    assign pad_fill = (r_final && (r_fill >= LEN_POS)) ? len_byte : 8'h00;

    // Sequencer and datapath next values.
    always_comb begin
        n_state        = r_state;
        n_fill         = r_fill;
        n_msg          = r_msg;
        n_h            = r_h;
        n_win          = r_win;
        n_cnt          = r_cnt;
        n_oidx         = r_oidx;
        n_pad          = r_pad;
        n_final        = r_final;
        round_ctl.load = 1'b0;
        round_ctl.step = (r_state == ST_ROUND);
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_fill = r_fill + 6'd1;
                    if (s_axis_tuser == FUNC_FINISH) begin
                        n_win   = {r_win[503:0], PAD_BYTE};
                        n_pad   = 1'b1;
                        n_final = (r_fill < LEN_POS);
                        n_state = ST_PAD;
                    end else begin
                        n_win = {r_win[503:0], s_axis_tdata};
                        n_msg = r_msg + 64'd1;
                    end
                    if (r_fill == LAST_POS) begin
                        n_state        = ST_ROUND;
                        n_cnt          = '0;
                        round_ctl.load = 1'b1;
                    end
                end
            end
            ST_PAD: begin
                n_win  = {r_win[503:0], pad_fill};
                n_fill = r_fill + 6'd1;
                if (r_fill == LAST_POS) begin
                    n_state        = ST_ROUND;
                    n_cnt          = '0;
                    round_ctl.load = 1'b1;
                end
            end
            ST_ROUND: begin
                n_win = {r_win[479:0], w_new};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == LAST_RND) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                for (int i = 0; i < NUM_WORDS; i++) begin
                    n_h[i] = r_h[i] + work[i];
                end
                if (r_final) begin
                    n_oidx  = '0;
                    n_state = ST_OUT;
                end else if (r_pad) begin
                    // Length did not fit: one more block of zeros and the length.
                    n_final = 1'b1;
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    for (int i = 0; i < NUM_WORDS - 1; i++) begin
                        n_h[i] = r_h[i + 1];
                    end
                    n_h[NUM_WORDS - 1] = r_h[0];
                    n_oidx             = r_oidx + 3'd1;
                    if (r_oidx == LAST_IDX) begin
                        // Restart for a new message.
                        for (int i = 0; i < NUM_WORDS; i++) begin
                            n_h[i] = H_INIT[i];
                        end
                        n_msg   = '0;
                        n_fill  = '0;
                        n_pad   = 1'b0;
                        n_final = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and chaining state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_msg   <= '0;
            r_cnt   <= '0;
            r_oidx  <= '0;
            r_pad   <= 1'b0;
            r_final <= 1'b0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_h[i] <= H_INIT[i];
            end
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_msg   <= n_msg;
            r_cnt   <= n_cnt;
            r_oidx  <= n_oidx;
            r_pad   <= n_pad;
            r_final <= n_final;
            r_h     <= n_h;
        end
    end

    // Block buffer doubling as the message schedule window.
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    shbs_round u_round (
        .i_clk  (i_clk),
        .i_ctl  (round_ctl),
        .i_init (r_h),
        .i_w    (r_win[511:480]),
        .i_k    (K_ROUND[r_cnt]),
        .o_work (work)
    );

    // Digest words leave from the head of the rotating chaining register.
    assign m_axis_tdata = r_h[0];
    assign m_axis_tuser = r_oidx;
    assign m_axis_tlast = (r_oidx == LAST_IDX);

endmodule

// ===== rtl/core/shbs_round.sv =====
// SHA-256 round unit: holds the working variables a..h and applies one round per step.
// Depends on shbs_pkg for the word types and the compression functions.

module shbs_round
    import shbs_pkg::*;
(
    input  logic       i_clk,
    input  t_round_ctl i_ctl,
    input  t_work      i_init,
    input  t_word      i_w,
    input  t_word      i_k,
    output t_work      o_work
);

    t_work r_v;
    t_work n_v;
    t_word t1;
    t_word t2;
    t_word choose;
    t_word major;

    // One round of the compression function.
    always_comb begin
        choose = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        major  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1     = r_v[7] + big_sigma1(r_v[4]) + choose + i_k + i_w;
        t2     = big_sigma0(r_v[0]) + major;
        n_v[7] = r_v[6];
        n_v[6] = r_v[5];
        n_v[5] = r_v[4];
        n_v[4] = r_v[3] + t1;
        n_v[3] = r_v[2];
        n_v[2] = r_v[1];
        n_v[1] = r_v[0];
        n_v[0] = t1 + t2;
    end

    // Working variables load from the chaining value, then step once per round.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= i_init;
        end else if (i_ctl.step) begin
            r_v <= n_v;
        end
    end

    assign o_work = r_v;

endmodule

// ===== rtl/core/shbs_checker.sv =====
// Port-level checks for the SHA-256 byte-stream hasher, bound to the top level.
// Depends only on the top level's port names.

module shbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // The block never takes input while digest words are pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while digest output is valid");

    // Only the word with index seven is flagged last.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("tlast does not match word index seven");

    // Digest words follow back to back with rising index until the last one.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (m_axis_tvalid && (m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1))))
        else $error("digest word sequence broken");

    // A finish transfer closes the input until the digest has gone out.
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
        else $error("input reopened right after a finish transfer");

    // A stalled digest word holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled digest word changed");

endmodule

bind sha256_byte_stream_hasher shbs_checker u_shbs_checker (.*);

// ===== verif/sha256_digest_checker.sv =====
`timescale 1ns / 1ps
// Checker for the SHA-256 byte-stream hasher: watches both stream ports, keeps its own
// SHA-256 model, and compares every digest word with the predicted one.
// Depends on shbs_pkg for the word type and the function codes.

module sha256_digest_checker
    import shbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] data_byte
    input  logic        i_s_tuser,    // [0] func
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,    // [31:0] digest_word
    input  logic [2:0]  i_m_tuser,    // [2:0] word_index
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    // One expected output transfer.
    typedef struct packed {
        t_word      word;
        logic [2:0] idx;
        logic       last;
    } t_digest_beat;

    localparam t_word IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Model state: chaining words, partial block, fill level and message length.
    t_word       chain [8];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [63:0] msg_len;

    t_digest_beat digest_q [$];
    int           fail_count = 0;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Runs the 64 rounds over the buffered block and folds the result into the chain.
    function automatic void compress_block();
        t_word w [64];
        t_word v [8];
        t_word s0, s1, t1, t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) begin
            v[i] = chain[i];
        end
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            chain[i] = chain[i] + v[i];
        end
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++) begin
            chain[i] = IV[i];
        end
        fill    = 0;
        msg_len = '0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] data_byte);
        blk[fill] = data_byte;
        fill      = fill + 1;
        msg_len   = msg_len + 1;
        if (fill == 64) begin
            compress_block();
            fill = 0;
        end
    endfunction

    // Pads the message, compresses the last block or two and queues the eight words.
    function automatic void finish_message();
        logic [63:0]  bit_len;
        t_digest_beat beat;
        bit_len   = msg_len << 3;
        blk[fill] = 8'h80;
        fill      = fill + 1;
        if (fill > 56) begin
            while (fill < 64) begin
                blk[fill] = 8'h00;
                fill      = fill + 1;
            end
            compress_block();
            fill = 0;
        end
        while (fill < 56) begin
            blk[fill] = 8'h00;
            fill      = fill + 1;
        end
        for (int i = 0; i < 8; i++) begin
            blk[63-i] = bit_len[8*i +: 8];
        end
        compress_block();
        for (int i = 0; i < 8; i++) begin
            beat.word = chain[i];
            beat.idx  = 3'(i);
            beat.last = (i == 7);
            digest_q.push_back(beat);
        end
        restart_message();
    endfunction

    function automatic void check_digest_word();
        t_digest_beat exp_beat;
        if (digest_q.size() == 0) begin
            $display("%0t: digest word %h (index %0d) with none expected",
                     $time, i_m_tdata, i_m_tuser);
            fail_count++;
        end else begin
            exp_beat = digest_q.pop_front();
            if (i_m_tdata !== exp_beat.word) begin
                $display("%0t: digest_word expected %h, actual %h",
                         $time, exp_beat.word, i_m_tdata);
                fail_count++;
            end
            if (i_m_tuser !== exp_beat.idx) begin
                $display("%0t: word_index expected %0d, actual %0d",
                         $time, exp_beat.idx, i_m_tuser);
                fail_count++;
            end
            if (i_m_tlast !== exp_beat.last) begin
                $display("%0t: last expected %b, actual %b",
                         $time, exp_beat.last, i_m_tlast);
                fail_count++;
            end
        end
    endfunction

    // Output transfers are checked before the input transfer of the same edge is modeled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_message();
            digest_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_digest_word();
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == FUNC_ABSORB) begin
                    absorb_byte(i_s_tdata);
                end else begin
                    finish_message();
                end
            end
        end
        o_pending    <= digest_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== verif/tb_sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
// Testbench top for the SHA-256 byte-stream hasher: clock, reset, byte and finish
// stimulus, output stalls, watchdog and verdict. Depends on shbs_pkg, the hasher and the checker.

module tb_sha256_byte_stream_hasher;
    import shbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 50;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser  = FUNC_ABSORB;   // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;   // [31:0] digest_word
    logic [2:0]  m_axis_tuser;   // [2:0] word_index
    logic        m_axis_tlast;

    int          fail_count;
    int          pending;
    int          ready_left  = 0;
    int          quiet_count = 0;
    bit          gapless     = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    sha256_byte_stream_hasher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha256_digest_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver stalls: mostly ready runs, short stalls, and now and then a long one.
    always @(posedge i_clk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            ready_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
            ready_left    <= $urandom_range(0, 40);
        end
    end

    // Watchdog on cycles without any transfer on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
        end
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Message lengths lean on the padding boundaries; a few messages span several blocks.
    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            case ($urandom_range(0, 9))
                0: return 0;
                1: return 1;
                2: return 55;
                3: return 56;
                4: return 57;
                5: return 63;
                6: return 64;
                7: return 65;
                8: return 119;
                default: return 120;
            endcase
        end
        if (roll < 80) return $urandom_range(0, 40);
        if (roll < 96) return $urandom_range(41, 130);
        return $urandom_range(131, 200);
    endfunction

    // Presents one input item after an optional gap and returns once it is transferred.
    task automatic send_item(input logic func, input logic [7:0] byte_val);
        int unsigned gap;
        gap = gapless ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            s_axis_tuser  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= byte_val;
        s_axis_tuser  <= func;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Holds the sender off until every pending digest word has been transferred.
    task automatic wait_for_digests();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned msg_bytes;
        int unsigned bytes_sent;
        int unsigned digests_asked;
        bytes_sent    = 0;
        digests_asked = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty message, ignored data byte on finish, and back-to-back restarts.
        send_item(FUNC_FINISH, 8'hFF);
        send_item(FUNC_FINISH, 8'h00);
        // The classic three-byte message.
        send_item(FUNC_ABSORB, 8'h61);
        send_item(FUNC_ABSORB, 8'h62);
        send_item(FUNC_ABSORB, 8'h63);
        send_item(FUNC_FINISH, 8'h5A);
        // Extreme byte values as one-byte messages.
        send_item(FUNC_ABSORB, 8'h00);
        send_item(FUNC_FINISH, 8'hA5);
        send_item(FUNC_ABSORB, 8'hFF);
        send_item(FUNC_FINISH, 8'h00);
        // Walking one across the data byte.
        for (int b = 0; b < 8; b++) begin
            send_item(FUNC_ABSORB, 8'(1 << b));
        end
        send_item(FUNC_FINISH, 8'hFF);
        wait_for_digests();

        // Random messages with random content until enough bytes and digests have gone.
        while (bytes_sent < 460 || digests_asked < 8) begin
            msg_bytes = pick_length();
            gapless   = ($urandom_range(0, 3) == 0);
            repeat (msg_bytes) begin
                send_item(FUNC_ABSORB, 8'($urandom_range(0, 255)));
                bytes_sent++;
            end
            send_item(FUNC_FINISH, 8'($urandom_range(0, 255)));
            digests_asked++;
            if ($urandom_range(0, 9) == 0) begin
                wait_for_digests();
            end
        end

        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sha256_byte_stream_hasher.f =====
rtl/core/shbs_pkg.sv
rtl/core/shbs_round.sv
rtl/core/sha256_byte_stream_hasher.sv
rtl/core/shbs_checker.sv
verif/sha256_digest_checker.sv
verif/tb_sha256_byte_stream_hasher.sv
